/* hdl/sitc_pkg.sv */
// shared constants and types for the sorted id table with contiguous prefix
package sitc_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ID_W   = 32;
    localparam int FUNC_W = 2;

    // stream word layouts
    localparam int S_TDATA_W = 48;   // list_id, position, zero fill
    localparam int M_TDATA_W = 32;   // found, index, status, entry_count, lowest_unused_id

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SEARCH = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_INS_LO_RD,
        ST_INS_LO_CMP,
        ST_INS_HI_RD,
        ST_INS_HI_CMP,
        ST_INS_PREP,
        ST_REM_PREP,
        ST_SHIFT,
        ST_INS_WRITE,
        ST_CT_RD,
        ST_CT_CMP,
        ST_DONE
    } state_t;

endpackage

/* hdl/sitc_ram.sv */
// generic simple dual-port ram with registered read
module sitc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/sorted_id_table_with_contig_prefix.sv */
// sorted id table with contiguous prefix: sequencer around one id ram and one comparator
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: func; tdata: list_id, position
//  m_      | out | m_tvalid/m_tready  | tdata: found, index, status, count, lowest id
//
// one word at a time; s_tready is high only while the sequencer is idle
// search: an id of zero or in the prefix needs no ram read, else a binary search above the prefix (at most 9 steps)
// insert: moves the entries from position up by one, writes the id, then grows the prefix; clear: empties the table
// remove: moves the entries above position down by one; the one-read one-write id ram sets the shift rate
// sync reset empties the table; ram contents need no clearing
// the last state waits only while the previous result word is still unclaimed
module sorted_id_table_with_contig_prefix (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sitc_pkg::S_TDATA_W-1:0]   s_tdata,   // list_id[31:0], position[40:32]
    input  logic [sitc_pkg::FUNC_W-1:0]      s_tuser,   // func[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sitc_pkg::M_TDATA_W-1:0]   m_tdata    // found[0], index[9:1], status[10],
                                                        // entry_count[19:11], lowest_unused_id[28:20]
);

    localparam int AW = sitc_pkg::ADDR_W;
    localparam int CW = sitc_pkg::CNT_W;
    localparam int IW = sitc_pkg::ID_W;

    sitc_pkg::state_t state_reg, state_next;

    sitc_pkg::func_t  func_reg, func_next;
    logic [IW-1:0]    id_reg, id_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    contig_reg, contig_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    waddr_reg, waddr_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic [CW-1:0]    index_reg, index_next;
    logic             status_reg, status_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [sitc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;

    // shared comparator: held id against the word just read
    logic id_lt, id_eq;
    assign id_lt = id_reg < ram_rdata;
    assign id_eq = id_reg == ram_rdata;

    logic          id_zero;
    logic          id_in_prefix;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid;
    logic [CW-1:0] contig_inc;
    logic          contig_match;
    logic          out_free;

    assign id_zero      = id_reg == '0;
    assign id_in_prefix = id_reg <= IW'(contig_reg);
    assign mid_sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid          = mid_sum[AW:1];
    assign contig_inc   = contig_reg + CW'(1);
    assign contig_match = ram_rdata == IW'(contig_inc);
    assign out_free     = !m_tvalid_reg || m_tready;

    sitc_ram #(
        .WIDTH(IW),
        .DEPTH(sitc_pkg::DEPTH)
    ) u_id_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sitc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sitc_pkg::ST_START;
                end
            end
            sitc_pkg::ST_START: begin
                unique case (func_reg)
                    sitc_pkg::FUNC_SEARCH: begin
                        if (id_zero || id_in_prefix) begin
                            state_next = sitc_pkg::ST_DONE;
                        end else begin
                            state_next = sitc_pkg::ST_SRCH_RD;
                        end
                    end
                    sitc_pkg::FUNC_INSERT: begin
                        if (id_zero || pos_reg > count_reg ||
                            count_reg >= CW'(sitc_pkg::DEPTH)) begin
                            state_next = sitc_pkg::ST_DONE;
                        end else begin
                            state_next = sitc_pkg::ST_INS_LO_RD;
                        end
                    end
                    sitc_pkg::FUNC_REMOVE: begin
                        if (pos_reg >= count_reg) begin
                            state_next = sitc_pkg::ST_DONE;
                        end else begin
                            state_next = sitc_pkg::ST_REM_PREP;
                        end
                    end
                    sitc_pkg::FUNC_CLEAR: begin
                        state_next = sitc_pkg::ST_DONE;
                    end
                    default: begin
                        state_next = sitc_pkg::ST_DONE;
                    end
                endcase
            end
            sitc_pkg::ST_SRCH_RD: begin
                if (lo_reg < hi_reg) begin
                    state_next = sitc_pkg::ST_SRCH_CMP;
                end else begin
                    state_next = sitc_pkg::ST_DONE;
                end
            end
            sitc_pkg::ST_SRCH_CMP: begin
                if (id_eq) begin
                    state_next = sitc_pkg::ST_DONE;
                end else begin
                    state_next = sitc_pkg::ST_SRCH_RD;
                end
            end
            sitc_pkg::ST_INS_LO_RD: begin
                if (pos_reg != '0) begin
                    state_next = sitc_pkg::ST_INS_LO_CMP;
                end else begin
                    state_next = sitc_pkg::ST_INS_HI_RD;
                end
            end
            sitc_pkg::ST_INS_LO_CMP: begin
                if (id_lt || id_eq) begin
                    state_next = sitc_pkg::ST_DONE;
                end else begin
                    state_next = sitc_pkg::ST_INS_HI_RD;
                end
            end
            sitc_pkg::ST_INS_HI_RD: begin
                if (pos_reg < count_reg) begin
                    state_next = sitc_pkg::ST_INS_HI_CMP;
                end else begin
                    state_next = sitc_pkg::ST_INS_PREP;
                end
            end
            sitc_pkg::ST_INS_HI_CMP: begin
                if (!id_lt) begin
                    state_next = sitc_pkg::ST_DONE;
                end else begin
                    state_next = sitc_pkg::ST_INS_PREP;
                end
            end
            sitc_pkg::ST_INS_PREP: begin
                state_next = sitc_pkg::ST_SHIFT;
            end
            sitc_pkg::ST_REM_PREP: begin
                state_next = sitc_pkg::ST_SHIFT;
            end
            sitc_pkg::ST_SHIFT: begin
                if (cnt_reg == '0) begin
                    if (func_reg == sitc_pkg::FUNC_INSERT) begin
                        state_next = sitc_pkg::ST_INS_WRITE;
                    end else begin
                        state_next = sitc_pkg::ST_DONE;
                    end
                end
            end
            sitc_pkg::ST_INS_WRITE: begin
                state_next = sitc_pkg::ST_CT_RD;
            end
            sitc_pkg::ST_CT_RD: begin
                if (contig_reg < count_reg) begin
                    state_next = sitc_pkg::ST_CT_CMP;
                end else begin
                    state_next = sitc_pkg::ST_DONE;
                end
            end
            sitc_pkg::ST_CT_CMP: begin
                if (!(contig_match && contig_inc < count_reg)) begin
                    state_next = sitc_pkg::ST_DONE;
                end
            end
            sitc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = sitc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sitc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        func_next     = func_reg;
        id_next       = id_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        contig_next   = contig_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        waddr_next    = waddr_reg;
        pend_next     = pend_reg;
        found_next    = found_reg;
        index_next    = index_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = waddr_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = '0;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            sitc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    func_next   = sitc_pkg::func_t'(s_tuser);
                    id_next     = s_tdata[IW-1:0];
                    pos_next    = s_tdata[IW+CW-1:IW];
                    found_next  = 1'b0;
                    index_next  = '0;
                    status_next = 1'b0;
                end
            end
            sitc_pkg::ST_START: begin
                unique case (func_reg)
                    sitc_pkg::FUNC_SEARCH: begin
                        if (!id_zero && id_in_prefix) begin
                            found_next = 1'b1;
                            index_next = id_reg[CW-1:0] - CW'(1);
                        end
                        lo_next = contig_reg;
                        hi_next = count_reg;
                    end
                    sitc_pkg::FUNC_INSERT: begin
                        if (id_zero || pos_reg > count_reg ||
                            count_reg >= CW'(sitc_pkg::DEPTH)) begin
                            status_next = 1'b1;
                        end
                    end
                    sitc_pkg::FUNC_REMOVE: begin
                        if (pos_reg >= count_reg) begin
                            status_next = 1'b1;
                        end
                    end
                    sitc_pkg::FUNC_CLEAR: begin
                        count_next  = '0;
                        contig_next = '0;
                    end
                    default: begin
                        status_next = 1'b0;
                    end
                endcase
            end
            sitc_pkg::ST_SRCH_RD: begin
                ram_raddr = mid;
                ptr_next  = mid;
                if (!(lo_reg < hi_reg)) begin
                    index_next = lo_reg;
                end
            end
            sitc_pkg::ST_SRCH_CMP: begin
                if (id_eq) begin
                    found_next = 1'b1;
                    index_next = CW'(ptr_reg);
                end else if (id_lt) begin
                    hi_next = CW'(ptr_reg);
                end else begin
                    lo_next = CW'(ptr_reg) + CW'(1);
                end
            end
            sitc_pkg::ST_INS_LO_RD: begin
                ram_raddr = AW'(pos_reg - CW'(1));
            end
            sitc_pkg::ST_INS_LO_CMP: begin
                if (id_lt || id_eq) begin
                    status_next = 1'b1;
                end
            end
            sitc_pkg::ST_INS_HI_RD: begin
                ram_raddr = pos_reg[AW-1:0];
            end
            sitc_pkg::ST_INS_HI_CMP: begin
                if (!id_lt) begin
                    status_next = 1'b1;
                end
            end
            sitc_pkg::ST_INS_PREP: begin
                cnt_next  = count_reg - pos_reg;
                ptr_next  = AW'(count_reg - CW'(1));
                pend_next = 1'b0;
            end
            sitc_pkg::ST_REM_PREP: begin
                count_next = count_reg - CW'(1);
                cnt_next   = count_reg - CW'(1) - pos_reg;
                ptr_next   = AW'(pos_reg + CW'(1));
                pend_next  = 1'b0;
                if (pos_reg < contig_reg) begin
                    contig_next = pos_reg;
                end
            end
            sitc_pkg::ST_SHIFT: begin
                // write back the word read last cycle while reading the next one
                ram_we    = pend_reg;
                ram_raddr = ptr_reg;
                if (cnt_reg != '0) begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg - CW'(1);
                    if (func_reg == sitc_pkg::FUNC_INSERT) begin
                        waddr_next = ptr_reg + AW'(1);
                        ptr_next   = ptr_reg - AW'(1);
                    end else begin
                        waddr_next = ptr_reg - AW'(1);
                        ptr_next   = ptr_reg + AW'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                end
            end
            sitc_pkg::ST_INS_WRITE: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = id_reg;
                count_next = count_reg + CW'(1);
            end
            sitc_pkg::ST_CT_RD: begin
                ram_raddr = contig_reg[AW-1:0];
            end
            sitc_pkg::ST_CT_CMP: begin
                // one prefix entry per cycle: compare current, read the next
                ram_raddr = contig_inc[AW-1:0];
                if (contig_match) begin
                    contig_next = contig_inc;
                end
            end
            sitc_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, contig_inc, count_reg, status_reg,
                                     index_reg, found_reg};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sitc_pkg::ST_IDLE;
            count_reg    <= '0;
            contig_reg   <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            contig_reg   <= contig_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        id_reg      <= id_next;
        pos_reg     <= pos_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        ptr_reg     <= ptr_next;
        cnt_reg     <= cnt_next;
        waddr_reg   <= waddr_next;
        found_reg   <= found_next;
        index_reg   <= index_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = state_reg == sitc_pkg::ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
